/* rtl/spc_pkg.sv */
// shared types, register indexes, health codes and reset values for the plausibility checker
package spc_pkg;

   localparam int unsigned SoilWidth  = 12;
   localparam int unsigned RunWidth   = 8;
   localparam int unsigned CsrIdxWidth  = 3;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [SoilWidth-1:0] SOIL_LIMIT = 12'd4095;

   typedef enum logic [1:0] {
      HEALTH_OK     = 2'd0,
      HEALTH_NOCOMM = 2'd1,
      HEALTH_RANGE  = 2'd2,
      HEALTH_INCONS = 2'd3
   } health_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_SOIL_STEP_LIMIT      = 3'd0,
      REG_LEAF_TEMP_MIN        = 3'd1,
      REG_LEAF_TEMP_MAX        = 3'd2,
      REG_LEAF_AIR_DELTA_LIMIT = 3'd3,
      REG_AIR_TEMP_MIN         = 3'd4,
      REG_AIR_TEMP_MAX         = 3'd5,
      REG_HUMIDITY_MAX         = 3'd6,
      REG_PERSIST_COUNT        = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic                 soil_ok;
      logic [15:0]          soil_raw;
      logic                 leaf_ok;
      logic signed [15:0]   leaf_temp;
      logic                 air_ok;
      logic signed [15:0]   air_temp;
      logic                 humidity_ok;
      logic [15:0]          humidity;
      logic                 lux_ok;
      logic [15:0]          lux_raw;
   } sample_type;

   typedef struct packed {
      logic [1:0] soil_health;
      logic [1:0] leaf_health;
      logic [1:0] air_humidity_health;
      logic [1:0] lux_health;
   } health_set_type;

   typedef struct packed {
      logic [SoilWidth-1:0] soil_step_limit;
      logic signed [15:0]   leaf_temp_min;
      logic signed [15:0]   leaf_temp_max;
      logic [15:0]          leaf_air_delta_limit;
      logic signed [15:0]   air_temp_min;
      logic signed [15:0]   air_temp_max;
      logic [15:0]          humidity_max;
      logic [RunWidth-1:0]  persist_count;
   } cfg_type;

   typedef struct packed {
      reg_idx_type             index;
      logic [CsrDataWidth-1:0] data;
   } csr_write_type;

   localparam cfg_type CFG_RESET = '{
      soil_step_limit:      12'd500,
      leaf_temp_min:        -16'sd1000,
      leaf_temp_max:        16'sd6000,
      leaf_air_delta_limit: 16'd1000,
      air_temp_min:         -16'sd2000,
      air_temp_max:         16'sd6000,
      humidity_max:         16'd10000,
      persist_count:        8'd3
   };

endpackage

/* rtl/spc_if.sv */
// valid/ready channel interfaces for samples, health results and register writes
interface spc_req_if;
   import spc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface spc_rsp_if;
   import spc_pkg::*;
   logic           valid;
   logic           ready;
   health_set_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface spc_csr_if;
   import spc_pkg::*;
   logic          valid;
   logic          ready;
   csr_write_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/spc_cfg_regs.sv */
// configuration register file written through the csr channel
module spc_cfg_regs (
   input  logic            clock,
   input  logic            reset,
   spc_csr_if.sink         csr_ch,
   output spc_pkg::cfg_type cfg
);
   import spc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.payload.index)
            REG_SOIL_STEP_LIMIT:
               cfg_in.soil_step_limit = csr_ch.payload.data[SoilWidth-1:0];
            REG_LEAF_TEMP_MIN:        cfg_in.leaf_temp_min = $signed(csr_ch.payload.data);
            REG_LEAF_TEMP_MAX:        cfg_in.leaf_temp_max = $signed(csr_ch.payload.data);
            REG_LEAF_AIR_DELTA_LIMIT: cfg_in.leaf_air_delta_limit = csr_ch.payload.data;
            REG_AIR_TEMP_MIN:         cfg_in.air_temp_min = $signed(csr_ch.payload.data);
            REG_AIR_TEMP_MAX:         cfg_in.air_temp_max = $signed(csr_ch.payload.data);
            REG_HUMIDITY_MAX:         cfg_in.humidity_max = csr_ch.payload.data;
            REG_PERSIST_COUNT:
               cfg_in.persist_count = csr_ch.payload.data[RunWidth-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/spc_check.sv */
// per-sample plausibility logic with the running soil, leaf-delta and dark history
module spc_check (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  spc_pkg::sample_type    sample,
   input  spc_pkg::cfg_type       cfg,
   output spc_pkg::health_set_type health
);
   import spc_pkg::*;

   logic [SoilWidth-1:0] prev_soil_ff, prev_soil_in;
   logic                 prev_seen_ff, prev_seen_in;
   logic [RunWidth-1:0]  delta_run_ff, delta_run_in;
   logic [RunWidth-1:0]  dark_run_ff, dark_run_in;

   logic [SoilWidth-1:0] soil_val;
   logic [SoilWidth-1:0] soil_diff;
   logic                 soil_in_range;
   logic signed [16:0]   leaf_air_diff;
   logic [16:0]          leaf_air_abs;
   logic                 leaf_in_range;
   logic                 air_in_range;
   logic [RunWidth-1:0]  delta_bump;
   logic [RunWidth-1:0]  dark_bump;

   assign soil_val      = sample.soil_raw[SoilWidth-1:0];
   assign soil_in_range = (sample.soil_raw[15:SoilWidth] == '0) && (soil_val <= SOIL_LIMIT);
   assign soil_diff     = (soil_val >= prev_soil_ff) ? soil_val - prev_soil_ff
                                                     : prev_soil_ff - soil_val;

   assign leaf_in_range = (sample.leaf_temp >= cfg.leaf_temp_min) &&
                          (sample.leaf_temp <= cfg.leaf_temp_max);
   assign leaf_air_diff = 17'(sample.leaf_temp) - 17'(sample.air_temp);
   assign leaf_air_abs  = leaf_air_diff[16] ? 17'(-leaf_air_diff) : 17'(leaf_air_diff);

   assign air_in_range  = (sample.air_temp >= cfg.air_temp_min) &&
                          (sample.air_temp <= cfg.air_temp_max) &&
                          (sample.humidity <= cfg.humidity_max);

   // run counters stop once they reach the persistence count
   assign delta_bump = (delta_run_ff < cfg.persist_count) ? delta_run_ff + 1'b1 : delta_run_ff;
   assign dark_bump  = (dark_run_ff < cfg.persist_count) ? dark_run_ff + 1'b1 : dark_run_ff;

   always_comb begin
      prev_soil_in = prev_soil_ff;
      prev_seen_in = prev_seen_ff;
      delta_run_in = delta_run_ff;
      dark_run_in  = dark_run_ff;

      if (!sample.soil_ok) begin
         health.soil_health = HEALTH_NOCOMM;
      end else if (!soil_in_range) begin
         health.soil_health = HEALTH_RANGE;
      end else begin
         // a flagged step still becomes the new reference reading
         prev_soil_in = soil_val;
         prev_seen_in = 1'b1;
         health.soil_health = (prev_seen_ff && (soil_diff > cfg.soil_step_limit))
                              ? HEALTH_RANGE : HEALTH_OK;
      end

      if (!sample.leaf_ok) begin
         health.leaf_health = HEALTH_NOCOMM;
         delta_run_in = '0;
      end else if (!leaf_in_range) begin
         health.leaf_health = HEALTH_RANGE;
         delta_run_in = '0;
      end else if (sample.air_ok && (leaf_air_abs > {1'b0, cfg.leaf_air_delta_limit})) begin
         delta_run_in = delta_bump;
         health.leaf_health = (delta_bump >= cfg.persist_count) ? HEALTH_INCONS : HEALTH_OK;
      end else begin
         delta_run_in = '0;
         health.leaf_health = HEALTH_OK;
      end

      if (!sample.air_ok || !sample.humidity_ok) begin
         health.air_humidity_health = HEALTH_NOCOMM;
      end else if (!air_in_range) begin
         health.air_humidity_health = HEALTH_RANGE;
      end else begin
         health.air_humidity_health = HEALTH_OK;
      end

      if (!sample.lux_ok) begin
         health.lux_health = HEALTH_NOCOMM;
         dark_run_in = '0;
      end else if (sample.lux_raw == '0) begin
         dark_run_in = dark_bump;
         health.lux_health = (dark_bump >= cfg.persist_count) ? HEALTH_INCONS : HEALTH_OK;
      end else begin
         dark_run_in = '0;
         health.lux_health = HEALTH_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_soil_ff <= '0;
         prev_seen_ff <= 1'b0;
         delta_run_ff <= '0;
         dark_run_ff  <= '0;
      end else if (advance) begin
         prev_soil_ff <= prev_soil_in;
         prev_seen_ff <= prev_seen_in;
         delta_run_ff <= delta_run_in;
         dark_run_ff  <= dark_run_in;
      end
   end

endmodule

/* rtl/sensor_plausibility_check.sv */
// an accepted sample set passes through the input register and the result register
// throughput: one sample set per cycle unless rsp_ch stalls; the input register and the
//   result register let a new transfer in while the previous result still waits
// reset: synchronous, active high; restores the register defaults and clears the soil
//   history and both run counters; the csr channel is always ready
module sensor_plausibility_check (
   input  logic      clock,
   input  logic      reset,
   spc_req_if.sink   req_ch,
   spc_rsp_if.source rsp_ch,
   spc_csr_if.sink   csr_ch
);
   import spc_pkg::*;

   logic           in_valid_ff;
   sample_type     in_data_ff;
   logic           out_valid_ff, out_valid_in;
   health_set_type out_data_ff;
   health_set_type health;
   cfg_type        cfg;
   logic           advance;

   // the input stage moves on when the result register is empty or being emptied
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_data_ff;

   spc_cfg_regs u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   spc_check u_check (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_data_ff),
      .cfg     (cfg),
      .health  (health)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff <= req_ch.payload;
      end
      if (advance) begin
         out_data_ff <= health;
      end
   end

`ifndef ASSERT_OFF
   a_fill_result: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("held sample did not reach the result register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && in_valid_ff |-> advance)
      else $error("input register overwritten before it moved on");

   a_code_sets: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.soil_health != HEALTH_INCONS) &&
                       (out_data_ff.air_humidity_health != HEALTH_INCONS) &&
                       (out_data_ff.lux_health != HEALTH_RANGE))
      else $error("health code outside the set for its channel");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> !$past(advance) || $past(in_valid_ff))
      else $error("result register loaded while stalled");
`endif

endmodule

/* sim/sensor_plausibility_check_tb.sv */
// self-checking testbench for the sensor plausibility checker: directed and random sample sets
module sensor_plausibility_check_tb;
   import spc_pkg::*;

   logic clock;
   logic reset;

   spc_req_if req_ch ();
   spc_rsp_if rsp_ch ();
   spc_csr_if csr_ch ();

   sensor_plausibility_check i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor copy of the registers
   logic [11:0]        step_limit_reg;
   logic signed [15:0] leaf_min_reg;
   logic signed [15:0] leaf_max_reg;
   logic [15:0]        delta_limit_reg;
   logic signed [15:0] air_min_reg;
   logic signed [15:0] air_max_reg;
   logic [15:0]        humidity_max_reg;
   logic [7:0]         persist_reg;

   // predictor copy of the running state
   logic [11:0] last_soil;
   logic        last_soil_valid;
   logic [7:0]  delta_run_len;
   logic [7:0]  dark_run_len;

   health_set_type expected_health[$];
   int unsigned    mismatch_count;
   int             send_idle_pct;
   int             stall_pct;
   int             gen_last_soil;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   function automatic void restore_defaults();
      step_limit_reg   = 12'd500;
      leaf_min_reg     = -16'sd1000;
      leaf_max_reg     = 16'sd6000;
      delta_limit_reg  = 16'd1000;
      air_min_reg      = -16'sd2000;
      air_max_reg      = 16'sd6000;
      humidity_max_reg = 16'd10000;
      persist_reg      = 8'd3;
      last_soil        = '0;
      last_soil_valid  = 1'b0;
      delta_run_len    = '0;
      dark_run_len     = '0;
   endfunction

   function automatic void write_predictor_reg(reg_idx_type idx, logic [15:0] data);
      case (idx)
         REG_SOIL_STEP_LIMIT:      step_limit_reg   = data[11:0];
         REG_LEAF_TEMP_MIN:        leaf_min_reg     = data;
         REG_LEAF_TEMP_MAX:        leaf_max_reg     = data;
         REG_LEAF_AIR_DELTA_LIMIT: delta_limit_reg  = data;
         REG_AIR_TEMP_MIN:         air_min_reg      = data;
         REG_AIR_TEMP_MAX:         air_max_reg      = data;
         REG_HUMIDITY_MAX:         humidity_max_reg = data;
         REG_PERSIST_COUNT:        persist_reg      = data[7:0];
         default: ;
      endcase
   endfunction

   // works out the four health codes and advances the running state
   function automatic health_set_type predict_health(sample_type s);
      health_set_type h;
      int             soil_diff;
      int             leaf_t;
      int             air_t;
      int             temp_diff;
      leaf_t = int'(s.leaf_temp);
      air_t  = int'(s.air_temp);

      if (!s.soil_ok) begin
         h.soil_health = HEALTH_NOCOMM;
      end else if (s.soil_raw > 16'd4095) begin
         h.soil_health = HEALTH_RANGE;
      end else begin
         soil_diff = int'(s.soil_raw) - int'(last_soil);
         if (soil_diff < 0) soil_diff = -soil_diff;
         h.soil_health = (last_soil_valid && soil_diff > int'(step_limit_reg)) ?
                         HEALTH_RANGE : HEALTH_OK;
         // flagged or not, the in-range reading becomes the new reference
         last_soil       = s.soil_raw[11:0];
         last_soil_valid = 1'b1;
      end

      if (!s.leaf_ok) begin
         h.leaf_health = HEALTH_NOCOMM;
         delta_run_len = '0;
      end else if (leaf_t < int'(leaf_min_reg) || leaf_t > int'(leaf_max_reg)) begin
         h.leaf_health = HEALTH_RANGE;
         delta_run_len = '0;
      end else if (s.air_ok) begin
         temp_diff = leaf_t - air_t;
         if (temp_diff < 0) temp_diff = -temp_diff;
         if (temp_diff > int'(delta_limit_reg)) begin
            if (delta_run_len < persist_reg) delta_run_len = delta_run_len + 8'd1;
            h.leaf_health = (delta_run_len >= persist_reg) ? HEALTH_INCONS : HEALTH_OK;
         end else begin
            delta_run_len = '0;
            h.leaf_health = HEALTH_OK;
         end
      end else begin
         delta_run_len = '0;
         h.leaf_health = HEALTH_OK;
      end

      if (!s.air_ok || !s.humidity_ok) begin
         h.air_humidity_health = HEALTH_NOCOMM;
      end else if (air_t < int'(air_min_reg) || air_t > int'(air_max_reg) ||
                   s.humidity > humidity_max_reg) begin
         h.air_humidity_health = HEALTH_RANGE;
      end else begin
         h.air_humidity_health = HEALTH_OK;
      end

      if (!s.lux_ok) begin
         h.lux_health = HEALTH_NOCOMM;
         dark_run_len = '0;
      end else if (s.lux_raw == 16'd0) begin
         if (dark_run_len < persist_reg) dark_run_len = dark_run_len + 8'd1;
         h.lux_health = (dark_run_len >= persist_reg) ? HEALTH_INCONS : HEALTH_OK;
      end else begin
         dark_run_len = '0;
         h.lux_health = HEALTH_OK;
      end
      return h;
   endfunction

   function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      health_set_type want;
      if (reset) begin
         restore_defaults();
         expected_health.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready)
            write_predictor_reg(csr_ch.payload.index, csr_ch.payload.data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_health.size() == 0) begin
               $error("health result with no sample set pending");
               mismatch_count++;
            end else begin
               want = expected_health.pop_front();
               check_field("soil_health", want.soil_health, rsp_ch.payload.soil_health);
               check_field("leaf_health", want.leaf_health, rsp_ch.payload.leaf_health);
               check_field("air_humidity_health", want.air_humidity_health,
                           rsp_ch.payload.air_humidity_health);
               check_field("lux_health", want.lux_health, rsp_ch.payload.lux_health);
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_health.push_back(predict_health(req_ch.payload));
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= (int'($urandom_range(99)) >= stall_pct);
   end

   function automatic sample_type make_sample(bit soil_ok, int soil_raw, bit leaf_ok,
                                              int leaf_t, bit air_ok, int air_t,
                                              bit humidity_ok, int humidity,
                                              bit lux_ok, int lux_raw);
      sample_type s;
      s.soil_ok     = soil_ok;
      s.soil_raw    = 16'(soil_raw);
      s.leaf_ok     = leaf_ok;
      s.leaf_temp   = 16'(leaf_t);
      s.air_ok      = air_ok;
      s.air_temp    = 16'(air_t);
      s.humidity_ok = humidity_ok;
      s.humidity    = 16'(humidity);
      s.lux_ok      = lux_ok;
      s.lux_raw     = 16'(lux_raw);
      return s;
   endfunction

   // mostly readings around the current limits, with some raw noise
   function automatic sample_type random_sample();
      sample_type  s;
      logic [95:0] noise;
      int          reach;
      int          span;
      int          value;
      int          leaf_t;
      if ($urandom_range(99) < 10) begin
         noise = {$urandom, $urandom, $urandom};
         s = noise[84:0];
         return s;
      end

      s.soil_ok = ($urandom_range(99) < 92);
      if ($urandom_range(99) < 80) begin
         reach = int'(step_limit_reg) + 64;
         value = gen_last_soil - reach + int'($urandom_range(2 * reach));
         if (value < 0) value = 0;
         if (value > 4095) value = 4095;
         s.soil_raw = 16'(value);
      end else begin
         s.soil_raw = 16'($urandom);
      end
      if (s.soil_ok && s.soil_raw <= 16'd4095) gen_last_soil = int'(s.soil_raw);

      s.leaf_ok = ($urandom_range(99) < 93);
      span = int'(leaf_max_reg) - int'(leaf_min_reg);
      if (span < 0) span = 0;
      leaf_t = int'(leaf_min_reg) - 300 + int'($urandom_range(span + 600));
      s.leaf_temp = 16'(leaf_t);

      s.air_ok = ($urandom_range(99) < 93);
      if ($urandom_range(99) < 80) begin
         reach = ((delta_limit_reg > 16'd3000) ? 3000 : int'(delta_limit_reg)) + 300;
         s.air_temp = 16'(leaf_t - reach + int'($urandom_range(2 * reach)));
      end else begin
         span = int'(air_max_reg) - int'(air_min_reg);
         if (span < 0) span = 0;
         s.air_temp = 16'(int'(air_min_reg) - 300 + int'($urandom_range(span + 600)));
      end

      s.humidity_ok = ($urandom_range(99) < 93);
      if ($urandom_range(99) < 85) begin
         value = int'(humidity_max_reg) - 300 + int'($urandom_range(600));
         if (value < 0) value = 0;
         if (value > 65535) value = 65535;
         s.humidity = 16'(value);
      end else begin
         s.humidity = 16'($urandom);
      end

      s.lux_ok = ($urandom_range(99) < 93);
      value = $urandom_range(99);
      if (value < 45)      s.lux_raw = '0;
      else if (value < 55) s.lux_raw = 16'($urandom);
      else                 s.lux_raw = 16'($urandom_range(2000, 1));
      return s;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_sample(sample_type s);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= s;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_health.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, int value);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= '{index: idx, data: value[15:0]};
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   task automatic apply_settings(int step, int leaf_lo, int leaf_hi, int delta, int air_lo,
                                 int air_hi, int hum_hi, int persist);
      settle();
      write_reg(REG_SOIL_STEP_LIMIT, step);
      write_reg(REG_LEAF_TEMP_MIN, leaf_lo);
      write_reg(REG_LEAF_TEMP_MAX, leaf_hi);
      write_reg(REG_LEAF_AIR_DELTA_LIMIT, delta);
      write_reg(REG_AIR_TEMP_MIN, air_lo);
      write_reg(REG_AIR_TEMP_MAX, air_hi);
      write_reg(REG_HUMIDITY_MAX, hum_hi);
      write_reg(REG_PERSIST_COUNT, persist);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random(int count);
      repeat (count) send_sample(random_sample());
   endtask

   task automatic test_soil();
      send_sample(make_sample(0, 65535, 1, 2000, 1, 2000, 1, 5000, 1, 500));
      // first in-range reading has no history to jump from
      send_sample(make_sample(1, 0, 1, 2000, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 4095, 1, 2000, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 4096, 1, 2000, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 65535, 1, 2000, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3595, 1, 2000, 1, 2000, 1, 5000, 1, 500));
   endtask

   task automatic test_leaf();
      send_sample(make_sample(1, 3600, 0, -32768, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3600, 1, -1001, 1, 2000, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3600, 1, 6001, 1, 2000, 1, 5000, 1, 500));
      // difference held past the limit until the run reaches the persist count
      repeat (4) send_sample(make_sample(1, 3600, 1, 6000, 1, 4999, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3600, 1, 6000, 0, -32768, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3600, 1, 32767, 1, 2000, 1, 5000, 1, 500));
   endtask

   task automatic test_air();
      send_sample(make_sample(1, 3600, 1, -1000, 1, -2000, 1, 10000, 1, 500));
      send_sample(make_sample(1, 3600, 1, 2000, 1, -2001, 1, 0, 1, 500));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 32767, 1, 5000, 1, 500));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 1, 65535, 1, 500));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 0, 5000, 1, 500));
   endtask

   task automatic test_lux();
      repeat (4) send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 1, 5000, 1, 0));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 1, 5000, 0, 0));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 1, 5000, 1, 0));
      send_sample(make_sample(1, 3600, 1, 2000, 1, 2000, 1, 5000, 1, 65535));
   endtask

   task automatic test_register_extremes();
      send_idle_pct = 10;
      stall_pct     = 10;
      // zero persist count and zero soil step and leaf-air delta limits
      apply_settings(0, -1000, 6000, 0, -2000, 6000, 10000, 0);
      send_random(30);
      // inverted limits
      apply_settings(4095, 1000, -1000, 1000, 5000, -5000, 0, 1);
      send_random(30);
      apply_settings(4095, -32768, 32767, 65535, -32768, 32767, 65535, 255);
      send_random(30);
   endtask

   task automatic test_run_saturation();
      send_idle_pct = 0;
      stall_pct     = 0;
      apply_settings(500, -1000, 6000, 1000, -2000, 6000, 10000, 255);
      repeat (260) send_sample(make_sample(1, 2000, 1, 3000, 1, 0, 1, 5000, 1, 0));
      send_sample(make_sample(1, 2000, 1, 3000, 1, 2900, 1, 5000, 1, 7));
   endtask

   task automatic test_random_traffic();
      apply_settings(500, -1000, 6000, 1000, -2000, 6000, 10000, 3);
      send_idle_pct = 0;
      stall_pct     = 0;
      send_random(105);
      apply_settings(100, -500, 4000, 300, -1000, 4500, 9000, 1);
      send_idle_pct = 47;
      stall_pct     = 0;
      send_random(105);
      apply_settings(2000, 0, 3000, 200, 0, 3500, 8000, 2);
      send_idle_pct = 0;
      stall_pct     = 47;
      send_random(105);
      apply_settings(50, -2000, 7000, 1500, -3000, 7000, 10000, 4);
      send_idle_pct = 10;
      stall_pct     = 10;
      send_random(105);
   endtask

   initial begin
      mismatch_count = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      gen_last_soil  = 2048;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      restore_defaults();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_soil();
      test_leaf();
      test_air();
      test_lux();
      test_register_extremes();
      test_run_saturation();
      test_random_traffic();

      settle();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_health.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
